[hdl/assert_macros.svh]
// Assertion macros shared by the serial endpoint RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usf assertion failed");

`endif

[hdl/usf_pkg.sv]
// Types, constants and helpers for the serial endpoint register block.
package usf_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int RAW_W      = 19;
    localparam int RX_FREE_W  = 7;
    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 8;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_HOST  = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_EP      = 8'h00;
    localparam logic [ADDR_W-1:0] ADDR_EP_CONF = 8'h04;
    localparam logic [ADDR_W-1:0] ADDR_INT_RAW = 8'h08;
    localparam logic [ADDR_W-1:0] ADDR_INT_ST  = 8'h0C;
    localparam logic [ADDR_W-1:0] ADDR_INT_ENA = 8'h10;
    localparam logic [ADDR_W-1:0] ADDR_INT_CLR = 8'h14;
    localparam logic [ADDR_W-1:0] ADDR_DATE    = 8'h80;

    localparam logic [DATA_W-1:0] DATE_VALUE = 32'h0201_2600;

    // raw interrupt bits
    localparam int RAW_FLUSH   = 0;
    localparam int RAW_FRAME   = 1;
    localparam int RAW_RXPKT   = 2;
    localparam int RAW_INEMPTY = 3;

    // endpoint conf bits
    localparam int CONF_FLUSH     = 0;
    localparam int CONF_IN_FREE   = 1;
    localparam int CONF_OUT_AVAIL = 2;

    localparam logic [RAW_W-1:0] RAW_RESET = RAW_W'(1) << RAW_INEMPTY;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
        logic [BYTE_W-1:0]   host_byte;
        logic                packet_end;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]    read_data;
        logic                 irq_level;
        logic [BYTE_W-1:0]    tx_byte;
        logic                 tx_valid;
        logic                 last_result;
        logic [RX_FREE_W-1:0] rx_free;
        logic                 rx_drained;
    } t_result;

    function automatic logic [IDX_W-1:0] usf_next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(FIFO_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

    // slot behind the last queued entry: head + count, wrapped once
    function automatic logic [IDX_W-1:0] usf_tail_idx(input logic [IDX_W-1:0] head,
                                                      input logic [CNT_W-1:0] count);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(count);
        if (sum >= SUM_W'(FIFO_DEPTH)) begin
            sum = sum - SUM_W'(FIFO_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[hdl/usf_ram.sv]
// Simple dual-port synchronous RAM, registered read with read enable.
module usf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/usf_core.sv]
// Sequencer, FIFO pointers and interrupt words around the transmit and receive memories.
module usf_core
    import usf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RES,
        ST_FLUSH
    } t_state;

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_pop, n_pop;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_tx_count, n_tx_count;
    logic [IDX_W-1:0]  r_tx_head, n_tx_head;
    logic [CNT_W-1:0]  r_rx_count, n_rx_count;
    logic [IDX_W-1:0]  r_rx_head, n_rx_head;
    logic [RAW_W-1:0]  r_irq_raw, n_irq_raw;
    logic [RAW_W-1:0]  r_irq_enable, n_irq_enable;

    logic              tx_we, tx_re;
    logic [IDX_W-1:0]  tx_waddr;
    logic [BYTE_W-1:0] tx_rdata;
    logic              rx_we, rx_re;
    logic [IDX_W-1:0]  rx_waddr;
    logic [BYTE_W-1:0] rx_rdata;
    logic [DATA_W-1:0] read_mux;

    usf_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_item.write_data[BYTE_W-1:0]),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    usf_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_item.host_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    assign tx_waddr = usf_tail_idx(r_tx_head, r_tx_count);
    assign rx_waddr = usf_tail_idx(r_rx_head, r_rx_count);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_pop        = r_pop;
        n_left       = r_left;
        n_tx_count   = r_tx_count;
        n_tx_head    = r_tx_head;
        n_rx_count   = r_rx_count;
        n_rx_head    = r_rx_head;
        n_irq_raw    = r_irq_raw;
        n_irq_enable = r_irq_enable;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_kind  = i_item.kind;
                    n_addr  = i_item.address;
                    n_pop   = 1'b0;
                    n_state = ST_RES;
                    case (i_item.kind)
                        KIND_READ: begin
                            if (i_item.address == ADDR_EP && r_rx_count != '0) begin
                                rx_re      = 1'b1;
                                n_rx_head  = usf_next_idx(r_rx_head);
                                n_rx_count = r_rx_count - CNT_W'(1);
                                n_pop      = 1'b1;
                            end
                        end
                        KIND_WRITE: begin
                            case (i_item.address)
                                ADDR_EP: begin
                                    if (r_tx_count != CNT_W'(FIFO_DEPTH)) begin
                                        tx_we      = 1'b1;
                                        n_tx_count = r_tx_count + CNT_W'(1);
                                    end
                                end
                                ADDR_EP_CONF: begin
                                    if (i_item.write_data[CONF_FLUSH]) begin
                                        n_irq_raw[RAW_INEMPTY] = 1'b1;
                                        n_tx_count             = '0;
                                        if (r_tx_count != '0) begin
                                            tx_re     = 1'b1;
                                            n_tx_head = usf_next_idx(r_tx_head);
                                            n_left    = r_tx_count;
                                            n_state   = ST_FLUSH;
                                        end
                                    end
                                end
                                ADDR_INT_ENA: begin
                                    n_irq_enable = i_item.write_data[RAW_W-1:0];
                                end
                                ADDR_INT_RAW, ADDR_INT_CLR: begin
                                    n_irq_raw = r_irq_raw & ~i_item.write_data[RAW_W-1:0];
                                end
                                default: begin
                                end
                            endcase
                        end
                        KIND_HOST: begin
                            if (r_rx_count != CNT_W'(FIFO_DEPTH)) begin
                                rx_we      = 1'b1;
                                n_rx_count = r_rx_count + CNT_W'(1);
                            end
                            if (i_item.packet_end) begin
                                n_irq_raw[RAW_RXPKT] = 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            n_irq_raw[RAW_FRAME] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                // one byte per transfer; next read issued as the current one leaves
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        tx_re     = 1'b1;
                        n_tx_head = usf_next_idx(r_tx_head);
                        n_left    = r_left - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_addr)
            ADDR_EP: begin
                read_mux = r_pop ? DATA_W'(rx_rdata) : '0;
            end
            ADDR_EP_CONF: begin
                read_mux                 = '0;
                read_mux[CONF_IN_FREE]   = 1'b1;
                read_mux[CONF_OUT_AVAIL] = (r_rx_count != '0);
            end
            ADDR_INT_RAW: read_mux = DATA_W'(r_irq_raw);
            ADDR_INT_ST:  read_mux = DATA_W'(r_irq_raw & r_irq_enable);
            ADDR_INT_ENA: read_mux = DATA_W'(r_irq_enable);
            ADDR_DATE:    read_mux = DATE_VALUE;
            default:      read_mux = '0;
        endcase
    end

    always_comb begin
        o_res.read_data   = (r_kind == KIND_READ) ? read_mux : '0;
        o_res.irq_level   = |(r_irq_raw & r_irq_enable);
        o_res.tx_byte     = (r_state == ST_FLUSH) ? tx_rdata : '0;
        o_res.tx_valid    = (r_state == ST_FLUSH);
        o_res.last_result = (r_state != ST_FLUSH) || (r_left == CNT_W'(1));
        o_res.rx_free     = RX_FREE_W'(FIFO_DEPTH) - RX_FREE_W'(r_rx_count);
        o_res.rx_drained  = r_pop && (r_kind == KIND_READ) && (r_rx_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_kind       <= KIND_READ;
            r_addr       <= '0;
            r_pop        <= 1'b0;
            r_left       <= '0;
            r_tx_count   <= '0;
            r_tx_head    <= '0;
            r_rx_count   <= '0;
            r_rx_head    <= '0;
            r_irq_raw    <= RAW_RESET;
            r_irq_enable <= '0;
        end else begin
            r_state      <= n_state;
            r_kind       <= n_kind;
            r_addr       <= n_addr;
            r_pop        <= n_pop;
            r_left       <= n_left;
            r_tx_count   <= n_tx_count;
            r_tx_head    <= n_tx_head;
            r_rx_count   <= n_rx_count;
            r_rx_head    <= n_rx_head;
            r_irq_raw    <= n_irq_raw;
            r_irq_enable <= n_irq_enable;
        end
    end

endmodule

[hdl/usb_serial_fifo_register_block.sv]
// Top level of the serial endpoint register block: stream ports and output register.
//
// One item is in work at a time. A bus access, host byte or frame tick does the
// state update (and, for an endpoint read, the receive memory read) in the accept
// cycle, then the result loads into the output register. A flush of n queued bytes
// streams them from the transmit memory's read port, one per cycle when the output
// side keeps up. The transmit and receive memories have a registered read and need
// no clearing pass after reset; the block can take an item as soon as reset is
// released.
`include "assert_macros.svh"

module usb_serial_fifo_register_block
    import usf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[7:0], write_data[39:8], host_byte[47:40]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  logic        s_axis_tlast,   // packet_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data[31:0], irq_level[32], tx_byte[40:33],
                                        // rx_free[47:41], rx_drained[48], zero[55:49]
    output logic        m_axis_tuser,   // tx_valid
    output logic        m_axis_tlast    // last_result
);

    t_item   item;
    t_result res;
    logic    res_valid;
    logic    res_ready;
    logic    r_out_valid;
    t_result r_out;

    assign item.kind       = t_kind'(s_axis_tuser);
    assign item.address    = s_axis_tdata[7:0];
    assign item.write_data = s_axis_tdata[39:8];
    assign item.host_byte  = s_axis_tdata[47:40];
    assign item.packet_end = s_axis_tlast;

    usf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.rx_drained, r_out.rx_free, r_out.tx_byte,
                            r_out.irq_level, r_out.read_data};
    assign m_axis_tuser  = r_out.tx_valid;
    assign m_axis_tlast  = r_out.last_result;

    `USF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `USF_ASSERT_IMPL(a_flush_no_read_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'h0)
    `USF_ASSERT_IMPL(a_rx_free_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[47:41] <= RX_FREE_W'(FIFO_DEPTH))
    `USF_ASSERT_IMPL(a_drained_all_free, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[48], m_axis_tdata[47:41] == RX_FREE_W'(FIFO_DEPTH))

endmodule
